### hw/rtl/bsrt_pkg.sv
package bsrt_pkg;

    localparam int SUBDIV_W       = 4;
    localparam int TPC_W          = 7;
    localparam int BPM_W          = 17;
    localparam int TICK_W         = 32;
    localparam int SPEED_W        = 24;
    localparam int PHASE_W        = 32;
    localparam int RPM_W          = 12;
    localparam int FRAC_W         = 16;
    localparam int CC_W           = 7;
    localparam int CFG_IDX_W      = 2;

    // shared divider geometry
    localparam int DVD_W          = 58;
    localparam int DEN_W          = 24;
    localparam int CNT_W          = 5;
    localparam int SPD_DVD_W      = 26;
    localparam int SPD_ITERS      = SPD_DVD_W / 2;
    localparam int PH_ITERS       = DVD_W / 2;

    localparam logic [SUBDIV_W-1:0] SUBDIV_REST    = 4'd0;
    localparam logic [SUBDIV_W-1:0] SUBDIV_QUARTER = 4'd2;
    localparam logic [SUBDIV_W-1:0] SUBDIV_LAST    = 4'd12;

    localparam logic [4:0]  TICKS_PER_QUARTER = 5'd24;
    localparam logic [24:0] TICK_SCALE        = 25'd20000000;  // 256 * 78125
    localparam logic [16:0] PHASE_DEN_K       = 17'd78125;
    localparam logic [3:0]  CAP_DEN           = 4'd15;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_RPM   = 2'd0,
        CFG_LEAD_US   = 2'd1,
        CFG_HORN_HOME = 2'd2,
        CFG_DRUM_HOME = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [RPM_W-1:0]  max_rpm;
        logic [FRAC_W-1:0] lead_us;
        logic [FRAC_W-1:0] horn_home;
        logic [FRAC_W-1:0] drum_home;
    } t_cfg;

    typedef struct packed {
        logic                req_type;
        logic                accepted;
        logic [SUBDIV_W-1:0] subdiv;
        logic [TPC_W-1:0]    horn_tpc;
        logic [TPC_W-1:0]    drum_tpc;
        logic [BPM_W-1:0]    bpm;
        logic [TICK_W-1:0]   ticks;
    } t_job;

    function automatic logic [TPC_W-1:0] horn_ticks(input logic [SUBDIV_W-1:0] s);
        logic [TPC_W-1:0] v;
        case (s)
            4'd0:    v = 7'd0;
            4'd1:    v = 7'd96;
            4'd2:    v = 7'd48;
            4'd3:    v = 7'd36;
            4'd4:    v = 7'd32;
            4'd5:    v = 7'd24;
            4'd6:    v = 7'd18;
            4'd7:    v = 7'd16;
            4'd8:    v = 7'd12;
            4'd9:    v = 7'd9;
            4'd10:   v = 7'd8;
            4'd11:   v = 7'd6;
            4'd12:   v = 7'd4;
            default: v = 7'd48;
        endcase
        return v;
    endfunction

    function automatic logic [TPC_W-1:0] drum_ticks(input logic [SUBDIV_W-1:0] s);
        logic [TPC_W-1:0] v;
        case (s)
            4'd0:                  v = 7'd0;
            4'd1:                  v = 7'd96;
            4'd2, 4'd3, 4'd4:      v = 7'd48;
            4'd5, 4'd6, 4'd7:      v = 7'd24;
            4'd8, 4'd9, 4'd10:     v = 7'd12;
            4'd11, 4'd12:          v = 7'd6;
            default:               v = 7'd48;
        endcase
        return v;
    endfunction

endpackage

### hw/rtl/bsrt_fifo.sv
module bsrt_fifo #(
    parameter int DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  bsrt_pkg::t_job    i_job,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_nempty,
    output bsrt_pkg::t_job    o_job
);
    import bsrt_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_FW = $clog2(DEPTH + 1);

    t_job              r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr, r_rd;
    logic [CNT_FW-1:0] r_cnt;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full   = (r_cnt == CNT_FW'(DEPTH));
    assign o_nempty = (r_cnt != '0);
    assign o_job    = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= bump(r_wr);
            if (i_pop)  r_rd <= bump(r_rd);
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (i_pop && !i_push) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

### hw/rtl/bsrt_front.sv
module bsrt_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          i_full,
    input  logic                          i_req_type,
    input  logic [bsrt_pkg::CC_W-1:0]     i_cc_value,
    input  logic [bsrt_pkg::BPM_W-1:0]    i_bpm,
    input  logic [bsrt_pkg::TICK_W-1:0]   i_tick_position,
    input  logic [bsrt_pkg::RPM_W-1:0]    i_max_rpm,
    output logic                          o_stall,
    output logic                          o_push,
    output bsrt_pkg::t_job                o_job
);
    import bsrt_pkg::*;

    logic [SUBDIV_W-1:0] r_subdiv, n_subdiv;
    logic [SUBDIV_W-1:0] idx;
    logic [TPC_W-1:0]    h_t, d_t, fast;
    logic [21:0]         lhs;
    logic [26:0]         rhs;
    logic                ok, take;

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        idx  = (i_cc_value > CC_W'(SUBDIV_LAST + 1'b1)) ? SUBDIV_LAST
                                                         : SUBDIV_W'(i_cc_value - 1'b1);
        h_t  = horn_ticks(idx);
        d_t  = drum_ticks(idx);
        fast = (h_t < d_t) ? h_t : d_t;
        lhs  = 22'(i_bpm) * 22'(TICKS_PER_QUARTER);
        rhs  = {19'(i_max_rpm) * 19'(fast), 8'd0};
        ok   = (idx == SUBDIV_REST) || (27'(lhs) <= rhs);
        take = !i_req_type && (i_cc_value != '0) && ok;
        n_subdiv = take ? idx : r_subdiv;

        o_job.req_type = i_req_type;
        o_job.accepted = take;
        o_job.subdiv   = n_subdiv;
        o_job.horn_tpc = horn_ticks(r_subdiv);
        o_job.drum_tpc = drum_ticks(r_subdiv);
        o_job.bpm      = i_bpm;
        o_job.ticks    = i_tick_position;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_subdiv <= SUBDIV_QUARTER;
        end else if (o_push) begin
            r_subdiv <= n_subdiv;
        end
    end

endmodule

### hw/rtl/bsrt_div.sv
module bsrt_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [bsrt_pkg::DVD_W-1:0]  i_dividend,
    input  logic [bsrt_pkg::DEN_W-1:0]  i_divisor,
    input  logic [bsrt_pkg::CNT_W-1:0]  i_iters,
    output logic                        o_done,
    output logic [bsrt_pkg::DVD_W-1:0]  o_quot,
    output logic                        o_rem_nz
);
    import bsrt_pkg::*;

    logic [DVD_W-1:0] r_dvd, r_quot;
    logic [DEN_W-1:0] r_rem, r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy, r_done;

    logic [DEN_W:0]   t1, t2;
    logic [DEN_W-1:0] rem1, rem2;
    logic             ge1, ge2;

    // two restoring steps per cycle
    always_comb begin
        t1   = {r_rem, r_dvd[DVD_W-1]};
        ge1  = (t1 >= {1'b0, r_den});
        rem1 = ge1 ? DEN_W'(t1 - {1'b0, r_den}) : DEN_W'(t1);
        t2   = {rem1, r_dvd[DVD_W-2]};
        ge2  = (t2 >= {1'b0, r_den});
        rem2 = ge2 ? DEN_W'(t2 - {1'b0, r_den}) : DEN_W'(t2);
    end

    assign o_done   = r_done;
    assign o_quot   = r_quot;
    assign o_rem_nz = (r_rem != '0);

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd  <= i_dividend;
            r_den  <= i_divisor;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_dvd  <= {r_dvd[DVD_W-3:0], 2'b00};
            r_rem  <= rem2;
            r_quot <= {r_quot[DVD_W-3:0], ge1, ge2};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_iters;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

### hw/rtl/bsrt_back.sv
module bsrt_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_nempty,
    input  bsrt_pkg::t_job                 i_job,
    input  bsrt_pkg::t_cfg                 i_cfg,
    input  logic                           i_stall,
    output logic                           o_pop,
    output logic                           o_valid,
    output logic                           o_accepted,
    output logic [bsrt_pkg::SUBDIV_W-1:0]  o_subdivision,
    output logic [bsrt_pkg::SPEED_W-1:0]   o_horn_speed,
    output logic [bsrt_pkg::PHASE_W-1:0]   o_horn_phase,
    output logic [bsrt_pkg::SPEED_W-1:0]   o_drum_speed,
    output logic [bsrt_pkg::PHASE_W-1:0]   o_drum_phase
);
    import bsrt_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SETUP = 6'b000010,
        S_SUB   = 6'b000100,
        S_SPD   = 6'b001000,
        S_PH    = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state              r_state, n_state;
    t_job                r_job;
    logic [56:0]         r_prod_t;
    logic [32:0]         r_prod_l;
    logic [DVD_W-1:0]    r_mag;
    logic                r_neg;
    logic                r_cap   [2];
    logic [SPEED_W-1:0]  r_speed [2];
    logic [PHASE_W-1:0]  r_phase [2];
    logic                r_out_valid;

    logic [TPC_W-1:0]    tpc     [2];
    logic [FRAC_W-1:0]   home    [2];
    logic [DVD_W-1:0]    dvd     [2];
    logic [DEN_W-1:0]    den     [2];
    logic [DVD_W-1:0]    quot    [2];
    logic                rem_nz  [2];
    logic                done    [2];
    logic [PHASE_W-1:0]  qlow    [2];
    logic [DVD_W:0]      diff;
    logic [CNT_W-1:0]    iters;
    logic                div_start, out_free, out_take;

    assign tpc[0]  = r_job.horn_tpc;
    assign tpc[1]  = r_job.drum_tpc;
    assign home[0] = i_cfg.horn_home;
    assign home[1] = i_cfg.drum_home;

    assign out_take  = r_out_valid && !i_stall;
    assign out_free  = !r_out_valid || out_take;
    assign o_pop     = (r_state == S_IDLE) && i_nempty;
    assign div_start = (r_state == S_SUB) || ((r_state == S_SPD) && done[0]);
    assign iters     = (r_state == S_SUB) ? CNT_W'(SPD_ITERS) : CNT_W'(PH_ITERS);
    assign diff      = {2'b00, r_prod_t} - {23'd0, r_prod_l, 3'b000};

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            if (r_state == S_SUB) begin
                dvd[l] = r_cap[l] ? {12'(i_cfg.max_rpm), 14'd0, 32'd0}
                                  : {r_job.bpm, 9'd0, 32'd0};
                den[l] = r_cap[l] ? DEN_W'(CAP_DEN) : DEN_W'(10'(tpc[l]) * 10'd5);
            end else begin
                dvd[l] = r_mag;
                den[l] = DEN_W'(tpc[l]) * DEN_W'(PHASE_DEN_K);
            end
            // floor toward minus infinity for a negative numerator
            if (!r_neg)         qlow[l] = quot[l][PHASE_W-1:0];
            else if (rem_nz[l]) qlow[l] = ~quot[l][PHASE_W-1:0];
            else                qlow[l] = -quot[l][PHASE_W-1:0];
        end
    end

    for (genvar g = 0; g < 2; g++) begin : g_lane
        bsrt_div u_div (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_start    (div_start),
            .i_dividend (dvd[g]),
            .i_divisor  (den[g]),
            .i_iters    (iters),
            .o_done     (done[g]),
            .o_quot     (quot[g]),
            .o_rem_nz   (rem_nz[g])
        );
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_nempty) n_state = i_job.req_type ? S_SETUP : S_DONE;
            S_SETUP: n_state = S_SUB;
            S_SUB:   n_state = S_SPD;
            S_SPD:   if (done[0]) n_state = S_PH;
            S_PH:    if (done[0]) n_state = S_DONE;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_job <= i_job;
        if (r_state == S_SETUP) begin
            r_prod_t <= 57'(r_job.ticks) * 57'(TICK_SCALE);
            r_prod_l <= 33'(i_cfg.lead_us) * 33'(r_job.bpm);
            for (int l = 0; l < 2; l++) begin
                r_cap[l] <= (24'(r_job.bpm) * 24'd3) >
                            {19'(tpc[l]) * 19'(i_cfg.max_rpm), 5'd0};
            end
        end
        if (r_state == S_SUB) begin
            r_neg <= diff[DVD_W];
            r_mag <= diff[DVD_W] ? DVD_W'(-diff) : diff[DVD_W-1:0];
        end
        for (int l = 0; l < 2; l++) begin
            if ((r_state == S_SPD) && done[0]) r_speed[l] <= quot[l][SPEED_W-1:0];
            if ((r_state == S_PH) && done[0])  r_phase[l] <= qlow[l] + PHASE_W'(home[l]);
        end
        if ((r_state == S_DONE) && out_free) begin
            o_accepted    <= r_job.accepted && !r_job.req_type;
            o_subdivision <= r_job.subdiv;
            o_horn_speed  <= (r_job.req_type && tpc[0] != '0) ? r_speed[0] : '0;
            o_horn_phase  <= (r_job.req_type && tpc[0] != '0) ? r_phase[0] : '0;
            o_drum_speed  <= (r_job.req_type && tpc[1] != '0) ? r_speed[1] : '0;
            o_drum_phase  <= (r_job.req_type && tpc[1] != '0) ? r_phase[1] : '0;
        end
    end

    assign o_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_DONE) && out_free) r_out_valid <= 1'b1;
            else if (out_take)                   r_out_valid <= 1'b0;
        end
    end

endmodule

### hw/rtl/beat_synced_rotor_target.sv
// Channel | Direction | Handshake             | Payload
// input   | in        | i_valid / o_stall     | req_type, cc_value, bpm, tick_position
// result  | out       | o_valid / i_stall     | accepted, subdivision, speeds, phases
// config  | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// A query goes from the queue to the result register through setup and subtract,
// then two radix-4 divider lanes run 13 steps for speed and 29 for phase.
// A select item skips the dividers; the subdivision is updated at accept.
// Synchronous active-low reset returns the subdivision to Quarter and loads the
// register defaults. Items queue while the back end works; input stalls when full.
module beat_synced_rotor_target #(
    parameter int FIFO_DEPTH = 2
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_req_type,
    input  logic [bsrt_pkg::CC_W-1:0]           i_cc_value,
    input  logic [bsrt_pkg::BPM_W-1:0]          i_bpm,
    input  logic [bsrt_pkg::TICK_W-1:0]         i_tick_position,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_accepted,
    output logic [bsrt_pkg::SUBDIV_W-1:0]       o_subdivision,
    output logic [bsrt_pkg::SPEED_W-1:0]        o_horn_speed,
    output logic [bsrt_pkg::PHASE_W-1:0]        o_horn_phase,
    output logic [bsrt_pkg::SPEED_W-1:0]        o_drum_speed,
    output logic [bsrt_pkg::PHASE_W-1:0]        o_drum_phase,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bsrt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bsrt_pkg::FRAC_W-1:0]         i_cfg_data
);
    import bsrt_pkg::*;

    t_cfg r_cfg;
    t_job fe_job, q_job;
    logic push, pop, full, nempty;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_rpm   <= RPM_W'(1200);
            r_cfg.lead_us   <= '0;
            r_cfg.horn_home <= '0;
            r_cfg.drum_home <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MAX_RPM:   r_cfg.max_rpm   <= i_cfg_data[RPM_W-1:0];
                CFG_LEAD_US:   r_cfg.lead_us   <= i_cfg_data;
                CFG_HORN_HOME: r_cfg.horn_home <= i_cfg_data;
                CFG_DRUM_HOME: r_cfg.drum_home <= i_cfg_data;
                default: ;
            endcase
        end
    end

    bsrt_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_full          (full),
        .i_req_type      (i_req_type),
        .i_cc_value      (i_cc_value),
        .i_bpm           (i_bpm),
        .i_tick_position (i_tick_position),
        .i_max_rpm       (r_cfg.max_rpm),
        .o_stall         (o_stall),
        .o_push          (push),
        .o_job           (fe_job)
    );

    bsrt_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (fe_job),
        .i_pop    (pop),
        .o_full   (full),
        .o_nempty (nempty),
        .o_job    (q_job)
    );

    bsrt_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_nempty      (nempty),
        .i_job         (q_job),
        .i_cfg         (r_cfg),
        .i_stall       (i_stall),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .o_accepted    (o_accepted),
        .o_subdivision (o_subdivision),
        .o_horn_speed  (o_horn_speed),
        .o_horn_phase  (o_horn_phase),
        .o_drum_speed  (o_drum_speed),
        .o_drum_phase  (o_drum_phase)
    );

endmodule
